>>> sv/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define AST_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked at every edge, reset included
`define AST_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> sv/hbd_pkg.sv
// types, constants and codes for the table bit decoder
// no dependencies; imported by every module of the block
package hbd_pkg;

    localparam int SYM_W              = 8;
    localparam int LEN_W              = 5;
    localparam int CODE_W             = 16;
    localparam int BYTE_W             = 8;
    localparam int BITS_W             = 4;
    localparam int GRP_SIZE           = 16;
    localparam int DEF_TABLE_ENTRIES  = 256;
    localparam int MAX_CODE_LEN       = 16;
    localparam int LEN_CMP_W          = LEN_W + 1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DECODE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic {
        KIND_SYMBOL   = 1'b0,
        KIND_OVERFLOW = 1'b1
    } t_kind;

    typedef struct packed {
        t_cmd                command;
        logic [BYTE_W-1:0]   data_byte;
        logic [BITS_W-1:0]   valid_bits;
        logic                final_byte;
        logic [SYM_W-1:0]    entry_symbol;
        logic [LEN_W-1:0]    entry_length;
        logic [CODE_W-1:0]   entry_code;
    } t_in_item;

    typedef struct packed {
        t_kind               kind;
        logic [SYM_W-1:0]    symbol;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [SYM_W-1:0]    symbol;
        logic [LEN_W-1:0]    length;
        logic [CODE_W-1:0]   code;
    } t_entry;

    typedef struct packed {
        logic [LEN_W-1:0]    length;
        logic [CODE_W-1:0]   code;
    } t_query;

    typedef struct packed {
        logic                found;
        logic [SYM_W-1:0]    symbol;
    } t_grp_res;

endpackage

>>> sv/hbd_cell.sv
// one table cell: holds one code entry, passes it on when the row shifts
// depends on hbd_pkg
module hbd_cell
    import hbd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_entry,
    input  t_query i_query,
    input  logic   i_occupied,
    output t_entry o_entry,
    output logic   o_hit
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = i_occupied && (r_entry.length == i_query.length)
                     && (r_entry.code == i_query.code);

endmodule

>>> sv/hbd_row.sv
// row of table cells, oldest entry furthest along, with registered per-group match
// depends on hbd_pkg and hbd_cell
module hbd_row
    import hbd_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    localparam int NUM_GRP      = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE,
    localparam int COUNT_W      = $clog2(TABLE_ENTRIES + 1)
)
(
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  t_entry                    i_load_entry,
    input  t_query                    i_query,
    input  logic [COUNT_W-1:0]        i_count,
    output t_grp_res [NUM_GRP-1:0]    o_grp
);

    t_entry                   cell_entry [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] cell_hit;
    t_grp_res [NUM_GRP-1:0]   r_grp;
    t_grp_res [NUM_GRP-1:0]   n_grp;

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
        t_entry     cell_in;
        logic       cell_occ;
        if (gi == 0) begin : g_head
            assign cell_in = i_load_entry;
        end else begin : g_body
            assign cell_in = cell_entry[gi-1];
        end
        assign cell_occ = (COUNT_W'(gi) < i_count);
        hbd_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_shift),
            .i_entry    (cell_in),
            .i_query    (i_query),
            .i_occupied (cell_occ),
            .o_entry    (cell_entry[gi]),
            .o_hit      (cell_hit[gi])
        );
    end

    // highest matching cell in each group is the oldest entry
    always_comb begin
        n_grp = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            for (int k = 0; k < GRP_SIZE; k++) begin
                if ((g * GRP_SIZE + k) < TABLE_ENTRIES) begin
                    if (cell_hit[g * GRP_SIZE + k]) begin
                        n_grp[g].found  = 1'b1;
                        n_grp[g].symbol = cell_entry[g * GRP_SIZE + k].symbol;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    assign o_grp = r_grp;

endmodule

>>> sv/huffman_table_bit_decoder.sv
// top level of the table driven bit decoder: control, accumulator, result staging
// depends on hbd_pkg, hbd_row, hbd_cell and assert_macros.svh
//
// input channel i_in_valid / o_in_ready carries t_in_item; output channel
// o_out_valid / i_out_ready carries t_out_item. a load shifts one entry into
// the cell row (ignored once the row is full) and a clear empties the row and
// the accumulator; both give no result.
// a decode byte takes a probe and a resolve step per used bit: the probe
// compares the accumulated code against every cell and registers the per-group
// matches, the resolve picks the oldest matching entry across groups and updates
// the accumulator. if a result is staged, a flush step then moves it out once
// the output is free; the next input is taken once the byte is finished.
// each result is held back one step so that its last flag is known; the
// previous one goes to the output register when the next appears.
// if the receiver stalls, decoding waits on the result that cannot move;
// the output register keeps its result while the next input is accepted.
// reset empties the table and the accumulator and drops any staged result;
// there is no clearing pass.
`include "assert_macros.svh"

module huffman_table_bit_decoder
    import hbd_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int NUM_GRP = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [LEN_CMP_W-1:0] MAX_LEN = LEN_CMP_W'(MAX_CODE_LEN);
    localparam logic [LEN_W-1:0]     LEN_TOP = {LEN_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_PROBE   = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_FLUSH   = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [CODE_W-1:0]    r_acc, n_acc;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [BYTE_W-1:0]    r_data, n_data;
    logic [BITS_W-1:0]    r_bits, n_bits;
    logic                 r_pend_valid, n_pend_valid;
    t_out_item            r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item, n_out_item;

    t_grp_res [NUM_GRP-1:0] grp;
    t_query               query;
    t_entry               load_entry;
    logic                 shift;
    logic                 in_xfer;
    logic                 out_free;
    logic                 hit;
    logic [SYM_W-1:0]     hit_sym;
    logic                 overflow;
    logic                 emit;
    logic [BITS_W-1:0]    use_bits;
    logic [BYTE_W-1:0]    aligned;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign query.code   = {r_acc[CODE_W-2:0], r_data[BYTE_W-1]};
    assign query.length = r_len + LEN_W'(1);

    assign load_entry.symbol = i_in_item.entry_symbol;
    assign load_entry.length = i_in_item.entry_length;
    assign load_entry.code   = i_in_item.entry_code;

    assign shift = in_xfer && (i_in_item.command == CMD_LOAD)
                   && (r_count < COUNT_W'(TABLE_ENTRIES));

    hbd_row #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_row (
        .i_clk        (i_clk),
        .i_shift      (shift),
        .i_load_entry (load_entry),
        .i_query      (query),
        .i_count      (r_count),
        .o_grp        (grp)
    );

    // oldest group with a match wins
    always_comb begin
        hit     = 1'b0;
        hit_sym = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            if (grp[g].found) begin
                hit     = 1'b1;
                hit_sym = grp[g].symbol;
            end
        end
    end

    assign overflow = !hit && (({1'b0, query.length} >= MAX_LEN)
                               || (query.length == LEN_TOP));
    assign emit     = hit || overflow;

    always_comb begin
        if (i_in_item.final_byte) begin
            use_bits = (i_in_item.valid_bits > BITS_W'(BYTE_W)) ? BITS_W'(BYTE_W)
                                                               : i_in_item.valid_bits;
        end else begin
            use_bits = BITS_W'(BYTE_W);
        end
        aligned = i_in_item.data_byte << (BITS_W'(BYTE_W) - use_bits);
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_acc        = r_acc;
        n_len        = r_len;
        n_data       = r_data;
        n_bits       = r_bits;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_item   = r_out_item;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_in_item.command)
                        CMD_LOAD: begin
                            if (shift) begin
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                        CMD_DECODE: begin
                            n_data = aligned;
                            n_bits = use_bits;
                            if (use_bits != '0) begin
                                n_state = S_PROBE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_acc   = '0;
                            n_len   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE: begin
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (!(emit && r_pend_valid && !out_free)) begin
                    if (emit) begin
                        n_acc         = '0;
                        n_len         = '0;
                        n_pend_valid  = 1'b1;
                        n_pend.kind   = hit ? KIND_SYMBOL : KIND_OVERFLOW;
                        n_pend.symbol = hit ? hit_sym : '0;
                        n_pend.last   = 1'b0;
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_item  = r_pend;
                        end
                    end else begin
                        n_acc = query.code;
                        n_len = query.length;
                    end
                    n_data = {r_data[BYTE_W-2:0], 1'b0};
                    n_bits = r_bits - BITS_W'(1);
                    if (r_bits == BITS_W'(1)) begin
                        n_state = (emit || r_pend_valid) ? S_FLUSH : S_IDLE;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_item      = r_pend;
                    n_out_item.last = 1'b1;
                    n_pend_valid    = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_acc        <= '0;
            r_len        <= '0;
            r_bits       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_acc        <= n_acc;
            r_len        <= n_len;
            r_bits       <= n_bits;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_pend     <= n_pend;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `AST_ON(a_flush_has_result, i_clk, i_rst_n, (r_state == S_FLUSH) |-> r_pend_valid)
    `AST_ON(a_idle_no_staged, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_pend_valid)
    `AST_ON(a_len_below_limit, i_clk, i_rst_n,
            (({1'b0, r_len} < MAX_LEN) && (r_len != LEN_TOP)))
    `AST_ON(a_count_in_range, i_clk, i_rst_n, r_count <= COUNT_W'(TABLE_ENTRIES))
    `AST_ON(a_probe_has_bits, i_clk, i_rst_n,
            ((r_state == S_PROBE) || (r_state == S_RESOLVE)) |-> (r_bits != '0))

endmodule
